/* hdl/hkra_pkg.sv */
// ----------------------------------------------------------------------------
// hkra_pkg
// Shared widths, register codes and the arctangent table for the hand
// keypoint rotation angle core.
// ----------------------------------------------------------------------------
package hkra_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 18;
  localparam int DIM_W   = 14;
  localparam int ANGLE_W = 16;

  // Internal datapath widths.
  // Weighted coordinate sum: |ix + rx + 2mx - 4wx| < 2^20.
  localparam int SUM_W    = 21;
  // Scaled direction component: |sum * size| < 2^34.
  localparam int PROD_W   = 35;
  // CORDIC vector: magnitude times the CORDIC gain stays below 2^36.
  localparam int CORDIC_W = 38;
  // Angle accumulator in Q.30, |z| stays below 2^32.
  localparam int Z_W      = 34;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TARGET = 2'd2
  } reg_idx_t;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 14'd1920;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 14'd1080;
  localparam logic [ANGLE_W-1:0] TARGET_RST = 16'd12868;

  // Angle constants in Q.30.
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // atan(2^-i) in Q.30, truncated.
  localparam int TABLE_LEN = 24;
  localparam logic signed [Z_W-1:0] ATAN_Q30 [TABLE_LEN] = '{
    34'h3243F6A8, 34'h1DAC6705, 34'h0FADBAFC, 34'h07F56EA6,
    34'h03FEAB76, 34'h01FFD55B, 34'h00FFFAAA, 34'h007FFF55,
    34'h003FFFEA, 34'h001FFFFD, 34'h000FFFFF, 34'h0007FFFF,
    34'h0003FFFF, 34'h0001FFFF, 34'h0000FFFF, 34'h00007FFF,
    34'h00003FFF, 34'h00001FFF, 34'h00000FFF, 34'h000007FF,
    34'h000003FF, 34'h000001FF, 34'h000000FF, 34'h0000007F
  };

endpackage

/* hdl/hand_keypoint_rotation_angle_core.sv */
// ----------------------------------------------------------------------------
// hand_keypoint_rotation_angle_core: wrist-to-finger hand rotation angle.
// Pipeline: sum, scale and quarter-turn stages, one register stage per CORDIC
// iteration, then the rounding and wrap stages before the result strobe.
// Throughput: one request per cycle, busy stays low; results cannot be held.
// Reset (synchronous, active low) empties the pipeline and restores registers.
// ----------------------------------------------------------------------------
module hand_keypoint_rotation_angle_core
  import hkra_pkg::*;
#(
  parameter int CORDIC_STEPS    = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Request channel
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_wrist_x,
  input  logic signed [COORD_W-1:0] in_wrist_y,
  input  logic signed [COORD_W-1:0] in_index_pip_x,
  input  logic signed [COORD_W-1:0] in_index_pip_y,
  input  logic signed [COORD_W-1:0] in_middle_pip_x,
  input  logic signed [COORD_W-1:0] in_middle_pip_y,
  input  logic signed [COORD_W-1:0] in_ring_pip_x,
  input  logic signed [COORD_W-1:0] in_ring_pip_y,
  // Result channel
  output logic                      out_valid,
  output logic signed [ANGLE_W-1:0] out_rotation,
  // Configuration port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  // Number of iterations: CORDIC_STEPS, capped at the length of the table.
  localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  // Rounding from Q.30 to the output angle format.
  localparam int     SHIFT  = 30 - ANGLE_FRAC_BITS;
  localparam longint RND    = 64'sd1 <<< (SHIFT - 1);
  localparam longint PI_Q   = (PI_Q30 + RND) >>> SHIFT;
  localparam longint TWO_PI = 2 * PI_Q;

  // Wrap range: r = target - angle is bounded by RMAX, an offset of whole
  // turns and half a turn makes it non-negative, and a short restoring reduction does the rest.
  localparam longint RMAX = 64'sd32768 + PI_Q + 64'sd16;
  localparam longint KT   = RMAX / TWO_PI + 64'sd1;
  localparam longint OFF  = PI_Q + KT * TWO_PI;
  localparam longint UMAX = RMAX + OFF;
  localparam int     UW   = $clog2(UMAX + 64'sd1) + 1;
  localparam int     NQ   = $clog2(UMAX / TWO_PI + 64'sd1);
  localparam int     AW   = Z_W + 1 - SHIFT;

  // Configuration registers.
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [ANGLE_W-1:0] target_r;
  logic               wr_en;

  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      target_r <= TARGET_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_TARGET: target_r <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_TARGET: prdata = DATA_W'(target_r);
      default:    prdata = '0;
    endcase
  end

  // The pipeline never stalls, so a request is always taken.
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 0: weighted sums of the keypoints relative to the wrist.
  logic                    sum_v_r;
  logic signed [SUM_W-1:0] sx_r, sy_r, sx_nxt, sy_nxt;

  always_comb begin
    sx_nxt = SUM_W'(in_index_pip_x) + SUM_W'(in_ring_pip_x)
           + (SUM_W'(in_middle_pip_x) <<< 1) - (SUM_W'(in_wrist_x) <<< 2);
    sy_nxt = (SUM_W'(in_wrist_y) <<< 2) - SUM_W'(in_index_pip_y)
           - SUM_W'(in_ring_pip_y) - (SUM_W'(in_middle_pip_y) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sum_v_r <= 1'b0;
    else        sum_v_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
  end

  // Stage 1: scale by the image size.
  logic                     prod_v_r;
  logic signed [PROD_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;

  always_comb begin
    dx_nxt = PROD_W'(sx_r) * PROD_W'($signed({1'b0, width_r}));
    dy_nxt = PROD_W'(sy_r) * PROD_W'($signed({1'b0, height_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else        prod_v_r <= sum_v_r;
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
  end

  // CORDIC pipeline; entry 0 holds the vector after the quarter-turn stage.
  logic                       cv_r   [0:NS];
  logic                       czero_r[0:NS];
  logic signed [CORDIC_W-1:0] cx_r   [0:NS];
  logic signed [CORDIC_W-1:0] cy_r   [0:NS];
  logic signed [Z_W-1:0]      cz_r   [0:NS];

  logic signed [CORDIC_W-1:0] px_nxt, py_nxt, ex, ey;
  logic signed [Z_W-1:0]      pz_nxt;

  // Stage 2: bring the vector into the right half plane.
  always_comb begin
    ex = CORDIC_W'(dx_r);
    ey = CORDIC_W'(dy_r);
    px_nxt = ex;
    py_nxt = ey;
    pz_nxt = '0;
    if (ex < 0) begin
      if (ey >= 0) begin
        px_nxt = ey;
        py_nxt = -ex;
        pz_nxt = Z_W'(HALF_PI_Q30);
      end else begin
        px_nxt = -ey;
        py_nxt = ex;
        pz_nxt = -Z_W'(HALF_PI_Q30);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else        cv_r[0] <= prod_v_r;
  end

  always_ff @(posedge clk) begin
    cx_r[0]    <= px_nxt;
    cy_r[0]    <= py_nxt;
    cz_r[0]    <= pz_nxt;
    czero_r[0] <= (dx_r == '0) && (dy_r == '0);
  end

  // One vectoring iteration per stage.
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [CORDIC_W-1:0] xs, ys, x_nxt, y_nxt;
    logic signed [Z_W-1:0]      z_nxt;

    always_comb begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (cy_r[i] > 0) begin
        x_nxt = cx_r[i] + ys;
        y_nxt = cy_r[i] - xs;
        z_nxt = cz_r[i] + ATAN_Q30[i];
      end else begin
        x_nxt = cx_r[i] - ys;
        y_nxt = cy_r[i] + xs;
        z_nxt = cz_r[i] - ATAN_Q30[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else        cv_r[i+1] <= cv_r[i];
    end

    always_ff @(posedge clk) begin
      cx_r[i+1]    <= x_nxt;
      cy_r[i+1]    <= y_nxt;
      cz_r[i+1]    <= z_nxt;
      czero_r[i+1] <= czero_r[i];
    end
  end

  // Rounding stage: round the angle, subtract it from the target and add
  // half a turn plus whole turns so that the difference is non-negative.
  logic                 u_v_r;
  logic [UW-1:0]        u_r, u_nxt;
  logic signed [Z_W:0]  zr;
  logic signed [AW-1:0] ang;
  logic signed [UW-1:0] diff;

  always_comb begin
    zr    = czero_r[NS] ? '0 : (Z_W+1)'(cz_r[NS]) + (Z_W+1)'(RND);
    ang   = AW'(zr >>> SHIFT);
    diff  = UW'($signed(target_r)) - UW'(ang) + UW'(OFF);
    u_nxt = diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) u_v_r <= 1'b0;
    else        u_v_r <= cv_r[NS];
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
  end

  // Wrap stage: reduce modulo two pi and recenter into [-pi, pi).
  logic               out_valid_r;
  logic [ANGLE_W-1:0] out_rot_r, rot_nxt;

  always_comb begin
    logic [UW-1:0] w;
    logic [UW-1:0] step;
    w = u_r;
    for (int j = NQ - 1; j >= 0; j--) begin
      step = UW'(TWO_PI << j);
      if (w >= step) w = w - step;
    end
    rot_nxt = ANGLE_W'(w - UW'(PI_Q));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= u_v_r;
  end

  always_ff @(posedge clk) begin
    out_rot_r <= rot_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_rotation = $signed(out_rot_r);

endmodule

/* hdl/hkra_checker.sv */
// ----------------------------------------------------------------------------
// hkra_checker
// Port-level checks of request-to-result timing and reset behavior.
// ----------------------------------------------------------------------------
module hkra_checker
  import hkra_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic pready
);

  localparam int NS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam int LAT = NS + 5;

  logic accept;
  assign accept = start && !busy;

  // Every request gives exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("request did not produce a result on time");

  // No result appears without a request.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |-> ##LAT !out_valid)
    else $error("result strobe without a matching request");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  // The core never holds off requests or register accesses.
  a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy && pready)
    else $error("core stalled a request");

endmodule

bind hand_keypoint_rotation_angle_core hkra_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_hkra_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .pready   (pready)
);
